/* sv/vvau_pkg.sv */
// Shared types and constants for the velocity Verlet atom update block.
`default_nettype none

package vvau_pkg;

	// Configuration register widths.
	localparam int TS_W = 25;
	localparam int BL_W = 47;

	// Register values after reset: dt of about 0.005 and a box of 10.0 in Q24.24.
	localparam logic [TS_W-1:0] TS_RESET = 25'd83886;
	localparam logic [BL_W-1:0] BL_RESET = 47'd167772160;

	// APB map: 64-bit registers at byte address 8*i.
	localparam int APB_DW  = 64;
	localparam int ADDR_W  = 4;
	localparam int REG_LSB = 3;

	typedef enum logic {
		REG_TIME_STEP  = 1'b0,
		REG_BOX_LENGTH = 1'b1
	} reg_idx_t;

	// Stage enables of the split multiplier.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} mul_en_t;

endpackage

`default_nettype wire

/* sv/vvau_mul_sat.sv */
// Three-stage split multiplier: unsigned a times signed b, arithmetic shift, saturate.
`default_nettype none

module vvau_mul_sat #(
	parameter int AW = 25,
	parameter int BW = 48,
	parameter int SH = 24
) (
	input  wire                    clk,
	input  vvau_pkg::mul_en_t      en,
	input  wire  [AW-1:0]          a,
	input  wire  signed [BW-1:0]   b,
	output logic signed [BW-1:0]   p
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW + 1;

	localparam logic signed [PW-1:0] SAT_HI = {{(PW-BW+1){1'b0}}, {(BW-1){1'b1}}};
	localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

	logic [AL-1:0]        alo;
	logic [AH-1:0]        ahi;
	logic [BL-1:0]        blo;
	logic signed [BH-1:0] bhi;

	logic [AL+BL-1:0]      pp_ll_s1;
	logic [AH+BL-1:0]      pp_hl_s1;
	logic signed [AL+BH:0] pp_lh_s1;
	logic signed [AH+BH:0] pp_hh_s1;

	logic [PW-1:0] lo_sum;
	logic [PW-1:0] hi_sum;
	logic [PW-1:0] p_lo_s2;
	logic [PW-1:0] p_hi_s2;

	logic [PW-1:0]        prod;
	logic signed [PW-1:0] prod_sh;
	logic signed [BW-1:0] sat_val;
	logic signed [BW-1:0] p_s3;

	assign alo = a[AL-1:0];
	assign ahi = a[AW-1:AL];
	assign blo = b[BL-1:0];
	assign bhi = b[BW-1:BL];

	// Partial products, each about half by half.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			pp_ll_s1 <= alo * blo;
			pp_hl_s1 <= ahi * blo;
			pp_lh_s1 <= $signed({1'b0, alo}) * bhi;
			pp_hh_s1 <= $signed({1'b0, ahi}) * bhi;
		end
	end

	// Combine the partial products that share an a half.
	always_comb begin
		lo_sum = {{(PW-AL-BL){1'b0}}, pp_ll_s1}
			+ ({{(PW-AL-BH-1){pp_lh_s1[AL+BH]}}, pp_lh_s1} << BL);
		hi_sum = {{(PW-AH-BL){1'b0}}, pp_hl_s1}
			+ ({{(PW-AH-BH-1){pp_hh_s1[AH+BH]}}, pp_hh_s1} << BL);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_lo_s2 <= lo_sum;
			p_hi_s2 <= hi_sum;
		end
	end

	// Full product, floor shift, clamp to the signed output range.
	always_comb begin
		prod    = p_lo_s2 + (p_hi_s2 << AL);
		prod_sh = $signed(prod) >>> SH;
		if (prod_sh > SAT_HI) begin
			sat_val = {1'b0, {(BW-1){1'b1}}};
		end else if (prod_sh < SAT_LO) begin
			sat_val = {1'b1, {(BW-1){1'b0}}};
		end else begin
			sat_val = prod_sh[BW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			p_s3 <= sat_val;
		end
	end

	assign p = p_s3;

endmodule

`default_nettype wire

/* sv/velocity_verlet_atom_update.sv */
// Top level of the velocity Verlet atom update pipeline.
//
// Each input item is one axis of one atom: position, velocity, force and the
// unwrapped displacement accumulator, all signed fixed point with FRAC_BITS
// fraction bits in DATA_WIDTH bits. With func 0 (first half step) the block
// computes step = dt*v + (dt*dt)*f/2, adds it to position and displacement,
// wraps the position once toward the box [0, L], and adds dt*f/2 to velocity.
// With func 1 (second half step) only velocity gains dt*f/2; position and
// displacement pass through. Products round toward minus infinity and every
// sum saturates. The pipeline takes one item per clock while the output takes
// its results, and has six register stages; a result waits in the last stage
// until it is taken. The depth comes from the three-stage split multipliers
// followed by three stages of saturating adds (step and velocity, position
// and displacement, box wrap). Each stage holds its own valid bit, so an item
// is taken whenever any stage downstream has room, even while a finished
// result waits on the output. dt*dt is formed when time_step is written, so
// an item may follow a configuration write on the next cycle. There is no
// clearing pass after reset.
`default_nettype none

module velocity_verlet_atom_update #(
	parameter int DATA_WIDTH = 48,
	parameter int FRAC_BITS  = 24
) (
	input  wire                                clk,
	input  wire                                arst_n,

	// Configuration: time_step at 0x0, box_length at 0x8.
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [vvau_pkg::ADDR_W-1:0]        paddr,
	input  wire  [vvau_pkg::APB_DW-1:0]        pwdata,
	output logic [vvau_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,

	// Input items.
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// position, velocity, force_req, displacement (lowest bits first)
	input  wire  [((4*DATA_WIDTH+7)/8)*8-1:0]  s_tdata,
	// func
	input  wire                                s_tuser,
	// last_atom
	input  wire                                s_tlast,

	// Result items.
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// position_out, velocity_out, displacement_out (lowest bits first)
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0]  m_tdata,
	// last_atom_out
	output logic                               m_tlast
);

	localparam int DW     = DATA_WIDTH;
	localparam int TS_W   = vvau_pkg::TS_W;
	localparam int BL_W   = vvau_pkg::BL_W;
	localparam int OUT_W  = ((3*DATA_WIDTH+7)/8)*8;
	localparam int DT2_W  = 2*TS_W - FRAC_BITS;
	// Wide enough to add a data word and the box length without overflow.
	localparam int SW     = ((DW > BL_W) ? DW : BL_W) + 2;

	localparam logic [2*TS_W-1:0] DT_SQ_RST =
		(2*TS_W)'(vvau_pkg::TS_RESET) * (2*TS_W)'(vvau_pkg::TS_RESET);
	localparam logic [DT2_W-1:0]  DT2_RST   = DT_SQ_RST[2*TS_W-1:FRAC_BITS];

	localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	// ---------------------------------------------------------------
	// Helpers
	// ---------------------------------------------------------------
	function automatic logic signed [SW-1:0] ext(input logic signed [DW-1:0] x);
		return {{(SW-DW){x[DW-1]}}, x};
	endfunction

	function automatic logic signed [DW-1:0] sat_sum(
		input logic signed [SW-1:0] a,
		input logic signed [SW-1:0] b
	);
		logic signed [SW-1:0] s;
		s = a + b;
		if (s > SAT_HI) begin
			return {1'b0, {(DW-1){1'b1}}};
		end else if (s < SAT_LO) begin
			return {1'b1, {(DW-1){1'b0}}};
		end
		return s[DW-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [TS_W-1:0]   time_step_q;
	logic [BL_W-1:0]   box_length_q;
	logic [DT2_W-1:0]  dt2_q;
	logic              cfg_wr;
	logic              reg_sel;
	logic [TS_W-1:0]   wr_ts;
	logic [2*TS_W-1:0] wr_ts_sq;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign reg_sel  = paddr[vvau_pkg::REG_LSB];
	assign wr_ts    = pwdata[TS_W-1:0];
	// Square dt on the write so the pipeline reads dt*dt from a register.
	assign wr_ts_sq = (2*TS_W)'(wr_ts) * (2*TS_W)'(wr_ts);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= vvau_pkg::TS_RESET;
			box_length_q <= vvau_pkg::BL_RESET;
			dt2_q        <= DT2_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				vvau_pkg::REG_TIME_STEP: begin
					time_step_q <= wr_ts;
					dt2_q       <= wr_ts_sq[2*TS_W-1:FRAC_BITS];
				end
				vvau_pkg::REG_BOX_LENGTH: begin
					box_length_q <= pwdata[BL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			vvau_pkg::REG_TIME_STEP:  prdata = vvau_pkg::APB_DW'(time_step_q);
			vvau_pkg::REG_BOX_LENGTH: prdata = vvau_pkg::APB_DW'(box_length_q);
			default:                  prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its item moves on.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	vvau_pkg::mul_en_t mul_en;

	assign adv6 = !v_s6 || m_tready;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign s_tready  = adv1;
	assign mul_en.s1 = adv1;
	assign mul_en.s2 = adv2;
	assign mul_en.s3 = adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stages 1-3: product dt*v and the halved products dt2*f and dt*f
	// ---------------------------------------------------------------
	logic signed [DW-1:0] in_pos, in_vel, in_force, in_disp;
	logic signed [DW-1:0] mul_dv, mul_d2f, mul_half;

	assign in_pos   = s_tdata[DW-1:0];
	assign in_vel   = s_tdata[2*DW-1:DW];
	assign in_force = s_tdata[3*DW-1:2*DW];
	assign in_disp  = s_tdata[4*DW-1:3*DW];

	vvau_mul_sat #(.AW(TS_W), .BW(DW), .SH(FRAC_BITS)) u_mul_dv (
		.clk (clk),
		.en  (mul_en),
		.a   (time_step_q),
		.b   (in_vel),
		.p   (mul_dv)
	);

	vvau_mul_sat #(.AW(DT2_W), .BW(DW), .SH(FRAC_BITS+1)) u_mul_d2f (
		.clk (clk),
		.en  (mul_en),
		.a   (dt2_q),
		.b   (in_force),
		.p   (mul_d2f)
	);

	vvau_mul_sat #(.AW(TS_W), .BW(DW), .SH(FRAC_BITS+1)) u_mul_half (
		.clk (clk),
		.en  (mul_en),
		.a   (time_step_q),
		.b   (in_force),
		.p   (mul_half)
	);

	// Carry the pass-through fields alongside the multipliers.
	logic signed [DW-1:0] pos_s1, pos_s2, pos_s3;
	logic signed [DW-1:0] vel_s1, vel_s2, vel_s3;
	logic signed [DW-1:0] disp_s1, disp_s2, disp_s3;
	logic                 func_s1, func_s2, func_s3;
	logic                 last_s1, last_s2, last_s3;

	always_ff @(posedge clk) begin
		if (adv1) begin
			pos_s1  <= in_pos;
			vel_s1  <= in_vel;
			disp_s1 <= in_disp;
			func_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
		if (adv2) begin
			pos_s2  <= pos_s1;
			vel_s2  <= vel_s1;
			disp_s2 <= disp_s1;
			func_s2 <= func_s1;
			last_s2 <= last_s1;
		end
		if (adv3) begin
			pos_s3  <= pos_s2;
			vel_s3  <= vel_s2;
			disp_s3 <= disp_s2;
			func_s3 <= func_s2;
			last_s3 <= last_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: step and the new velocity
	// ---------------------------------------------------------------
	logic signed [DW-1:0] step_s4, pos_s4, vel_s4, disp_s4;
	logic                 func_s4, last_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			step_s4 <= sat_sum(ext(mul_dv), ext(mul_d2f));
			vel_s4  <= sat_sum(ext(vel_s3), ext(mul_half));
			pos_s4  <= pos_s3;
			disp_s4 <= disp_s3;
			func_s4 <= func_s3;
			last_s4 <= last_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: advance position and displacement on the first half step
	// ---------------------------------------------------------------
	logic signed [DW-1:0] pos_s5, vel_s5, disp_s5;
	logic                 func_s5, last_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			if (!func_s4) begin
				pos_s5  <= sat_sum(ext(pos_s4), ext(step_s4));
				disp_s5 <= sat_sum(ext(disp_s4), ext(step_s4));
			end else begin
				pos_s5  <= pos_s4;
				disp_s5 <= disp_s4;
			end
			vel_s5  <= vel_s4;
			func_s5 <= func_s4;
			last_s5 <= last_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: single periodic wrap, then hold for the output handshake
	// ---------------------------------------------------------------
	logic signed [SW-1:0] len_w;
	logic signed [SW-1:0] pos_w;
	logic signed [DW-1:0] pos_wrap;
	logic signed [DW-1:0] pos_s6, vel_s6, disp_s6;
	logic                 last_s6;

	assign len_w = {{(SW-BL_W){1'b0}}, box_length_q};
	assign pos_w = ext(pos_s5);

	always_comb begin
		if (func_s5) begin
			pos_wrap = pos_s5;
		end else if (pos_s5[DW-1]) begin
			pos_wrap = sat_sum(pos_w, len_w);
		end else if (pos_w > len_w) begin
			pos_wrap = sat_sum(pos_w, -len_w);
		end else begin
			pos_wrap = pos_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			pos_s6  <= pos_wrap;
			vel_s6  <= vel_s5;
			disp_s6 <= disp_s5;
			last_s6 <= last_s5;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = OUT_W'({disp_s6, vel_s6, pos_s6});
	assign m_tlast  = last_s6;

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the velocity Verlet atom update pipeline.
module testbench;

	localparam int DW = 48;
	localparam int FRAC = 24;
	localparam int S_BITS = ((4*DW+7)/8)*8;
	localparam int M_BITS = ((3*DW+7)/8)*8;
	// Quiet cycles tolerated before the run is declared hung: far beyond the longest
	// sender gap plus the longest output stall plus the time through the pipeline.
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int REPORT_LIMIT = 10;

	localparam logic FUNC_FIRST_HALF = 1'b0;
	localparam logic FUNC_SECOND_HALF = 1'b1;

	typedef logic signed [DW-1:0] q_t;
	typedef logic signed [127:0] wide_t;

	localparam q_t Q_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam q_t Q_MIN = 48'sh8000_0000_0000;
	localparam wide_t W_MAX = 128'(Q_MAX);
	localparam wide_t W_MIN = 128'(Q_MIN);

	typedef struct {
		logic func;
		q_t   pos;
		q_t   vel;
		q_t   frc;
		q_t   disp;
		logic last;
	} atom_axis_t;

	typedef struct {
		q_t   pos;
		q_t   vel;
		q_t   disp;
		logic last;
	} axis_update_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE_STALL,
		READY_LONG_STALL
	} ready_mode_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [vvau_pkg::ADDR_W-1:0] paddr;
	logic [vvau_pkg::APB_DW-1:0] pwdata;
	logic [vvau_pkg::APB_DW-1:0] prdata;
	logic                        pready;
	logic                        s_tvalid;
	logic                        s_tready;
	// position, velocity, force_req, displacement (lowest bits first)
	logic [S_BITS-1:0]           s_tdata;
	// func
	logic                        s_tuser;
	// last_atom
	logic                        s_tlast;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	// position_out, velocity_out, displacement_out (lowest bits first)
	logic [M_BITS-1:0]           m_tdata;
	// last_atom_out
	logic                        m_tlast;

	// Shadow copies of the configuration registers, updated on each write.
	logic [vvau_pkg::TS_W-1:0] time_step_q = vvau_pkg::TS_RESET;
	logic [vvau_pkg::BL_W-1:0] box_length_q = vvau_pkg::BL_RESET;

	axis_update_t predicted_axes[$];
	int           mismatch_count = 0;
	int           quiet_cycles = 0;

	ready_mode_t  ready_mode = READY_ALWAYS;
	int           mode_left = 0;
	int           stall_left = 0;

	velocity_verlet_atom_update #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FRAC)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial clk = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Fixed-point predictor
	// ---------------------------------------------------------------------

	// Clamp an exact wide value to the signed 48-bit range.
	function automatic q_t clamp_q(wide_t a);
		if (a > W_MAX)
			return Q_MAX;
		if (a < W_MIN)
			return Q_MIN;
		return a[DW-1:0];
	endfunction

	function automatic q_t sat_sum(q_t a, wide_t b);
		wide_t wa;
		wa = 128'(a);
		return clamp_q(wa + b);
	endfunction

	// Exact unsigned-by-signed product, arithmetic shift (rounds toward minus
	// infinity), then clamp.
	function automatic q_t scaled_product(logic [63:0] mult, q_t val, int shift);
		wide_t pu;
		wide_t ps;
		wide_t prod;
		pu = {64'b0, mult};
		ps = 128'(val);
		prod = pu * ps;
		return clamp_q(prod >>> shift);
	endfunction

	function automatic axis_update_t verlet_update(atom_axis_t a);
		axis_update_t r;
		logic [63:0]  dt64;
		logic [63:0]  dt2;
		wide_t        box_w;
		wide_t        pos_w;
		q_t           half;
		q_t           step;
		dt64 = 64'(time_step_q);
		dt2 = (dt64 * dt64) >> FRAC;
		box_w = {81'b0, box_length_q};
		half = scaled_product(dt64, a.frc, FRAC + 1);
		r.pos = a.pos;
		r.disp = a.disp;
		r.last = a.last;
		if (a.func == FUNC_FIRST_HALF) begin
			step = sat_sum(scaled_product(dt64, a.vel, FRAC),
				128'(scaled_product(dt2, a.frc, FRAC + 1)));
			r.pos = sat_sum(a.pos, 128'(step));
			r.disp = sat_sum(a.disp, 128'(step));
			// Wrap once only: a coordinate far outside the box stays outside.
			pos_w = 128'(r.pos);
			if (pos_w < 0)
				r.pos = sat_sum(r.pos, box_w);
			else if (pos_w > box_w)
				r.pos = sat_sum(r.pos, -box_w);
		end
		r.vel = sat_sum(a.vel, 128'(half));
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic q_t fx(int whole);
		return q_t'(whole) <<< FRAC;
	endfunction

	function automatic atom_axis_t axis(logic func, q_t pos, q_t vel, q_t frc, q_t disp,
		logic last);
		atom_axis_t a;
		a.func = func;
		a.pos = pos;
		a.vel = vel;
		a.frc = frc;
		a.disp = disp;
		a.last = last;
		return a;
	endfunction

	// Mix of full-range noise, extremes and physically sized values.
	function automatic q_t random_q();
		logic [63:0]        r;
		logic signed [31:0] s32;
		logic signed [39:0] s40;
		r = {$urandom, $urandom};
		s32 = r[31:0];
		s40 = r[39:0];
		case ($urandom_range(0, 7))
			0, 1: return r[DW-1:0];
			2: return Q_MAX;
			3: return Q_MIN;
			4: return q_t'(s32);
			5: return q_t'(int'($urandom_range(0, 64)) - 32);
			default: return q_t'(s40);
		endcase
	endfunction

	// Bias coordinates toward the box and its two walls to exercise the wrap.
	function automatic q_t random_position();
		q_t          box;
		logic [63:0] r;
		box = q_t'(box_length_q);
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return random_q();
			1: return box + q_t'(int'($urandom_range(0, 64)) - 32);
			2: return q_t'(int'($urandom_range(0, 64)) - 32);
			3, 4: return q_t'(r % (64'(box_length_q) + 64'd1));
			default: return q_t'(r % (64'(box_length_q) * 3 + 64'd1)) - box;
		endcase
	endfunction

	// Present one item at the falling edge and hold it until it is taken; leave
	// tvalid high so a back-to-back item follows without a bubble.
	task automatic send_axis(input atom_axis_t a);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = a.func;
		s_tlast = a.last;
		s_tdata = {a.disp, a.frc, a.vel, a.pos};
		do
			@(posedge clk);
		while (!s_tready);
		predicted_axes.push_back(verlet_update(a));
	endtask

	// Drop tvalid for a number of cycles and scramble the idle bus.
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		s_tuser = 1'($urandom_range(0, 1));
		s_tlast = 1'($urandom_range(0, 1));
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic finish_phase();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (predicted_axes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input vvau_pkg::reg_idx_t idx, input logic [63:0] value);
		logic [vvau_pkg::ADDR_W-1:0] addr;
		addr = vvau_pkg::ADDR_W'(idx);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr << vvau_pkg::REG_LSB;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			vvau_pkg::REG_TIME_STEP: time_step_q = value[vvau_pkg::TS_W-1:0];
			vvau_pkg::REG_BOX_LENGTH: box_length_q = value[vvau_pkg::BL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Random items in passes closed by the last flag, sent in bursts.
	task automatic stream_random_axes(input int count, input bit gappy);
		atom_axis_t a;
		int         burst_left;
		int         pass_left;
		burst_left = $urandom_range(1, 40);
		pass_left = $urandom_range(1, 48);
		for (int i = 0; i < count; i++) begin
			a.func = $urandom_range(0, 1) ? FUNC_SECOND_HALF : FUNC_FIRST_HALF;
			a.pos = random_position();
			a.vel = random_q();
			a.frc = random_q();
			a.disp = random_q();
			pass_left--;
			a.last = (pass_left == 0);
			if (pass_left == 0)
				pass_left = $urandom_range(1, 48);
			send_axis(a);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if (gappy)
					pause_sender($urandom_range(1, 12));
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset configuration: ordinary motion, both walls, far-out coordinates and
	// saturation on every field.
	task automatic test_directed_reset_config();
		q_t box;
		box = q_t'(vvau_pkg::BL_RESET);
		send_axis(axis(FUNC_FIRST_HALF, 0, 0, 0, 0, 1'b0));
		send_axis(axis(FUNC_SECOND_HALF, fx(5), fx(1), fx(2), fx(3), 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, fx(5), fx(1), -fx(2), 0, 1'b0));
		// cross the lower wall
		send_axis(axis(FUNC_FIRST_HALF, 1, -fx(100), 0, 0, 1'b0));
		// cross the upper wall
		send_axis(axis(FUNC_FIRST_HALF, box - 16, fx(100), 0, 0, 1'b0));
		// sitting exactly on each wall
		send_axis(axis(FUNC_FIRST_HALF, box, 0, 0, 0, 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, 0, 0, 0, fx(7), 1'b0));
		// more than one box away: one wrap leaves it outside
		send_axis(axis(FUNC_FIRST_HALF, -3 * box, 0, 0, 0, 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, 4 * box, 0, 0, 0, 1'b1));
		send_axis(axis(FUNC_FIRST_HALF, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
		send_axis(axis(FUNC_FIRST_HALF, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
		send_axis(axis(FUNC_SECOND_HALF, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1));
		send_axis(axis(FUNC_SECOND_HALF, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, 0, Q_MAX, Q_MIN, 0, 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, -1, -1, -1, -1, 1'b1));
		finish_phase();
	endtask

	// Largest time step (beyond 1.0) and largest box, written with junk above
	// the register width; then a zero box, where the wrap changes nothing.
	task automatic test_directed_extreme_config();
		write_register(vvau_pkg::REG_TIME_STEP, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(vvau_pkg::REG_BOX_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_axis(axis(FUNC_FIRST_HALF, fx(1), fx(3), -fx(5), 0, 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, -1, Q_MAX, Q_MAX, Q_MAX, 1'b0));
		send_axis(axis(FUNC_SECOND_HALF, 0, -fx(2), Q_MAX, 0, 1'b1));
		finish_phase();
		write_register(vvau_pkg::REG_BOX_LENGTH, 64'd0);
		send_axis(axis(FUNC_FIRST_HALF, fx(1), -fx(1000), 0, 0, 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, fx(5), fx(1), 0, 0, 1'b0));
		send_axis(axis(FUNC_FIRST_HALF, Q_MIN, Q_MIN, 0, 0, 1'b1));
		finish_phase();
	endtask

	// Random items under a series of settings: the reset values, then extremes, then random ones.
	task automatic test_random_sweep();
		logic [63:0] dt_val;
		logic [63:0] box_val;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					dt_val = 64'(vvau_pkg::TS_RESET);
					box_val = 64'(vvau_pkg::BL_RESET);
				end
				1: begin
					dt_val = 64'd1 << FRAC;
					box_val = 64'd1;
				end
				2: begin
					dt_val = 64'd0;
					box_val = 64'd0;
				end
				3: begin
					dt_val = (64'd1 << vvau_pkg::TS_W) - 1;
					box_val = (64'd1 << vvau_pkg::BL_W) - 1;
				end
				default: begin
					if ($urandom_range(0, 1))
						dt_val = 64'($urandom_range(0, 1 << 22));
					else
						dt_val = 64'($urandom_range(0, (1 << vvau_pkg::TS_W) - 1));
					if ($urandom_range(0, 1))
						box_val = 64'($urandom_range(1 << FRAC, 1 << 30));
					else
						box_val = {$urandom, $urandom} & ((64'd1 << vvau_pkg::BL_W) - 1);
				end
			endcase
			write_register(vvau_pkg::REG_TIME_STEP, dt_val);
			write_register(vvau_pkg::REG_BOX_LENGTH, box_val);
			// one phase runs the sender flat out
			stream_random_axes(PHASE_ITEMS, p != 5);
			finish_phase();
		end
	endtask

	// ---------------------------------------------------------------------
	// Output side: stall pattern, result check, watchdog
	// ---------------------------------------------------------------------

	// Switch the stall pattern each time the current spell runs out, including spells where
	// the output is always ready.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(32, 300);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			READY_ALWAYS: m_tready = 1'b1;
			READY_COIN: m_tready = 1'($urandom_range(0, 1));
			READY_SPARSE_STALL: m_tready = ($urandom_range(0, 7) != 0);
			default: begin
				if (stall_left != 0) begin
					m_tready = 1'b0;
					stall_left--;
				end else begin
					m_tready = 1'b1;
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 12);
				end
			end
		endcase
	end

	// Compare each result taken with the oldest prediction, field by field.
	always @(posedge clk) begin
		axis_update_t want;
		q_t           got_pos;
		q_t           got_vel;
		q_t           got_disp;
		if (arst_n && m_tvalid && m_tready) begin
			got_pos = m_tdata[DW-1:0];
			got_vel = m_tdata[2*DW-1:DW];
			got_disp = m_tdata[3*DW-1:2*DW];
			if (predicted_axes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result with nothing pending: pos %0d vel %0d disp %0d",
						$time, got_pos, got_vel, got_disp);
			end else begin
				want = predicted_axes.pop_front();
				if (got_pos !== want.pos || got_vel !== want.vel ||
					got_disp !== want.disp || m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: mismatch", $time);
						$display("  position     exp %0d got %0d", want.pos, got_pos);
						$display("  velocity     exp %0d got %0d", want.vel, got_vel);
						$display("  displacement exp %0d got %0d", want.disp, got_disp);
						$display("  last         exp %0b got %0b", want.last, m_tlast);
					end
				end
			end
		end
	end

	// End the run when nothing moves on either stream or the register port.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		// Hold reset, then release it on a falling edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_reset_config();
		test_directed_extreme_config();
		test_random_sweep();

		// Let any stray result surface before the verdict.
		finish_phase();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
